/* rtl/stc_pkg.sv */
package stc_pkg;

	localparam int unsigned DIV_STAGES = 64;

	localparam logic [2:0] REG_TEMP_TRIM  = 3'd0;
	localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
	localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
	localparam logic [2:0] REG_PRESS_LAST = 3'd3;
	localparam logic [2:0] REG_HUM_TRIM   = 3'd4;
	localparam logic [2:0] REG_HUM_PRES   = 3'd5;

	localparam logic [63:0] P_TEMP_OFS  = 64'd128000;
	localparam logic [63:0] P_RAW_FULL  = 64'd1048576;
	localparam logic [63:0] P_SCALE     = 64'd3125;
	localparam logic [63:0] P_ONE_47    = 64'h0000_8000_0000_0000;
	localparam logic [31:0] H_TEMP_OFS  = 32'd76800;
	localparam logic [31:0] H_ROUND_LHS = 32'd16384;
	localparam logic [31:0] H_OFS_H3    = 32'd32768;
	localparam logic [31:0] H_OFS_RHS   = 32'd2097152;
	localparam logic [31:0] H_ROUND_RHS = 32'd8192;
	localparam logic [31:0] H_MAX       = 32'd419430400;

endpackage

/* rtl/sensor_trim_compensation.sv */
// Integer trim compensation for a temperature, pressure and humidity sensor.
// Input stream: one beat per raw sample triple on s_tvalid/s_tready/s_tdata.
// Output stream: one beat per input beat, in order, on m_tvalid/m_tready/m_tdata,
// with m_tuser set when the pressure result is valid (nonzero divisor).
// Trim words are written through the APB port at byte address 8*i; pready is
// always high and reads return the register value. Trim words must only be
// changed while no beat is in flight.
// From an accepted input beat to its output beat the pipeline has eleven
// arithmetic stages, a 64-stage restoring divider that resolves one quotient
// bit per stage, and four stages after it. The pipeline takes one beat every
// cycle unless the output stalls; the divider's one-bit-per-stage chain sets the latency.
// Reset clears all trim registers and empties the pipeline.
// When m_tready is low with a beat waiting, the whole pipeline holds and
// s_tready drops in the same cycle; nothing is lost or repeated.
module sensor_trim_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // temp_centi[15:0], press_q24_8[47:16], hum_q22_10[64:48]
	output logic [0:0]  m_tuser,   // press_valid[0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import stc_pkg::*;

	function automatic logic [31:0] sra32(logic [31:0] v, int n);
		return $signed(v) >>> n;
	endfunction

	function automatic logic [63:0] sra64(logic [63:0] v, int n);
		return $signed(v) >>> n;
	endfunction

	logic [47:0] temp_trim_q;
	logic [63:0] press_lo_q, press_hi_q, hum_trim_q;
	logic [15:0] press_last_q;
	logic        hum_pres_q;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q  <= '0;
			press_lo_q   <= '0;
			press_hi_q   <= '0;
			press_last_q <= '0;
			hum_trim_q   <= '0;
			hum_pres_q   <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_TEMP_TRIM:  temp_trim_q  <= pwdata[47:0];
				REG_PRESS_LOW:  press_lo_q   <= pwdata;
				REG_PRESS_HIGH: press_hi_q   <= pwdata;
				REG_PRESS_LAST: press_last_q <= pwdata[15:0];
				REG_HUM_TRIM:   hum_trim_q   <= pwdata;
				REG_HUM_PRES:   hum_pres_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TEMP_TRIM:  prdata = {16'd0, temp_trim_q};
			REG_PRESS_LOW:  prdata = press_lo_q;
			REG_PRESS_HIGH: prdata = press_hi_q;
			REG_PRESS_LAST: prdata = {48'd0, press_last_q};
			REG_HUM_TRIM:   prdata = hum_trim_q;
			REG_HUM_PRES:   prdata = {63'd0, hum_pres_q};
			default:        prdata = '0;
		endcase
	end

	logic [31:0] t1, t2, t3;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] h1, h2, h3, h4, h5, h6;

	assign t1 = {16'd0, temp_trim_q[15:0]};
	assign t2 = {{16{temp_trim_q[31]}}, temp_trim_q[31:16]};
	assign t3 = {{16{temp_trim_q[47]}}, temp_trim_q[47:32]};
	assign p1 = {48'd0, press_lo_q[15:0]};
	assign p2 = {{48{press_lo_q[31]}}, press_lo_q[31:16]};
	assign p3 = {{48{press_lo_q[47]}}, press_lo_q[47:32]};
	assign p4 = {{48{press_lo_q[63]}}, press_lo_q[63:48]};
	assign p5 = {{48{press_hi_q[15]}}, press_hi_q[15:0]};
	assign p6 = {{48{press_hi_q[31]}}, press_hi_q[31:16]};
	assign p7 = {{48{press_hi_q[47]}}, press_hi_q[47:32]};
	assign p8 = {{48{press_hi_q[63]}}, press_hi_q[63:48]};
	assign p9 = {{48{press_last_q[15]}}, press_last_q};
	assign h1 = {24'd0, hum_trim_q[7:0]};
	assign h2 = {{16{hum_trim_q[23]}}, hum_trim_q[23:8]};
	assign h3 = {24'd0, hum_trim_q[31:24]};
	assign h4 = {{20{hum_trim_q[43]}}, hum_trim_q[43:32]};
	assign h5 = {{20{hum_trim_q[55]}}, hum_trim_q[55:44]};
	assign h6 = {{24{hum_trim_q[63]}}, hum_trim_q[63:56]};

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_s12, v_s13, v_s14, v_s15;
	logic div_v_s [DIV_STAGES];

	assign en       = !v_s15 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11} <= '0;
			{v_s12, v_s13, v_s14, v_s15} <= '0;
		end else if (en) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= div_v_s[DIV_STAGES-1];
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	logic [31:0] ta_s1, d_s1, aprod_s2, dd_s2, a_s3, bprod_s3, tf_s4;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7, adcp_s8,
		adcp_s9;
	logic [15:0] adch_s1, adch_s2, adch_s3, adch_s4, adch_s5, adch_s6;
	logic [15:0] tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10, tc_s11;
	logic [63:0] v1_s5, vv_s6, v1p5_s6, v1p2_s6, vvp6_s7, vvp3_s7, v2a_s7, v1b_s7;
	logic [63:0] v2_s8, v1c_s8, v1d_s9, v2_s9, den_s10, num_s10;
	logic [31:0] hx_s5, h5x_s6, xh6_s6, xh3_s6, lhs_s7, r1_s7, lhs_s8, r2h_s8;
	logic [31:0] xp_s9, xp_s10, yy_s10, xp_s11, ht_s11;
	logic [63:0] an_s11, ad_s11;
	logic        neg_s11, dz_s11;

	logic [31:0] adc_t, tf5, tcu, r2, rhs, y;
	logic [15:0] tc_sat;

	assign adc_t = {12'd0, s_tdata[19:0]};
	assign tf5   = (tf_s4 << 2) + tf_s4 + 32'd128;
	assign tcu   = $signed(tf5) >>> 8;
	assign r2    = sra32(r1_s7, 10) + H_OFS_RHS;
	assign rhs   = $signed(r2h_s8 + H_ROUND_RHS) >>> 14;
	assign y     = $signed(xp_s9) >>> 15;

	always_comb begin
		if ($signed(tcu) > $signed(32'sd32767)) begin
			tc_sat = 16'h7FFF;
		end else if ($signed(tcu) < $signed(-32'sd32768)) begin
			tc_sat = 16'h8000;
		end else begin
			tc_sat = tcu[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s1    <= (adc_t >> 3) - (t1 << 1);
			d_s1     <= (adc_t >> 4) - t1;
			adcp_s1  <= s_tdata[39:20];
			adch_s1  <= s_tdata[55:40];

			aprod_s2 <= ta_s1 * t2;
			dd_s2    <= d_s1 * d_s1;
			adcp_s2  <= adcp_s1;
			adch_s2  <= adch_s1;

			a_s3     <= $signed(aprod_s2) >>> 11;
			bprod_s3 <= sra32(dd_s2, 12) * t3;
			adcp_s3  <= adcp_s2;
			adch_s3  <= adch_s2;

			tf_s4    <= a_s3 + sra32(bprod_s3, 14);
			adcp_s4  <= adcp_s3;
			adch_s4  <= adch_s3;

			tc_s5    <= tc_sat;
			v1_s5    <= {{32{tf_s4[31]}}, tf_s4} - P_TEMP_OFS;
			hx_s5    <= tf_s4 - H_TEMP_OFS;
			adcp_s5  <= adcp_s4;
			adch_s5  <= adch_s4;

			vv_s6    <= 64'($signed(v1_s5[32:0]) * $signed(v1_s5[32:0]));
			v1p5_s6  <= v1_s5 * p5;
			v1p2_s6  <= v1_s5 * p2;
			h5x_s6   <= h5 * hx_s5;
			xh6_s6   <= hx_s5 * h6;
			xh3_s6   <= hx_s5 * h3;
			tc_s6    <= tc_s5;
			adcp_s6  <= adcp_s5;
			adch_s6  <= adch_s5;

			vvp6_s7  <= vv_s6 * p6;
			vvp3_s7  <= vv_s6 * p3;
			v2a_s7   <= (v1p5_s6 << 17) + (p4 << 35);
			v1b_s7   <= v1p2_s6 << 12;
			lhs_s7   <= $signed(({16'd0, adch_s6} << 14) - (h4 << 20) - h5x_s6
				+ H_ROUND_LHS) >>> 15;
			r1_s7    <= sra32(xh6_s6, 10) * (sra32(xh3_s6, 11) + H_OFS_H3);
			tc_s7    <= tc_s6;
			adcp_s7  <= adcp_s6;

			v2_s8    <= vvp6_s7 + v2a_s7;
			v1c_s8   <= sra64(vvp3_s7, 8) + v1b_s7;
			r2h_s8   <= r2 * h2;
			lhs_s8   <= lhs_s7;
			tc_s8    <= tc_s7;
			adcp_s8  <= adcp_s7;

			v1d_s9   <= (P_ONE_47 + v1c_s8) * p1;
			v2_s9    <= v2_s8;
			xp_s9    <= lhs_s8 * rhs;
			tc_s9    <= tc_s8;
			adcp_s9  <= adcp_s8;

			den_s10  <= $signed(v1d_s9) >>> 33;
			num_s10  <= (((P_RAW_FULL - {44'd0, adcp_s9}) << 31) - v2_s9) * P_SCALE;
			yy_s10   <= y * y;
			xp_s10   <= xp_s9;
			tc_s10   <= tc_s9;

			an_s11   <= num_s10[63] ? (64'd0 - num_s10) : num_s10;
			ad_s11   <= den_s10[63] ? (64'd0 - den_s10) : den_s10;
			neg_s11  <= num_s10[63] ^ den_s10[63];
			dz_s11   <= (den_s10 == 64'd0);
			ht_s11   <= sra32(yy_s10, 7) * h1;
			xp_s11   <= xp_s10;
			tc_s11   <= tc_s10;
		end
	end

	logic [31:0] hx2;
	logic [16:0] hum_fin;

	assign hx2 = xp_s11 - sra32(ht_s11, 4);

	always_comb begin
		if (!hum_pres_q || $signed(hx2) < $signed(32'sd0)) begin
			hum_fin = '0;
		end else if ($signed(hx2) > $signed(H_MAX)) begin
			hum_fin = H_MAX[28:12];
		end else begin
			hum_fin = hx2[28:12];
		end
	end

	logic [63:0] div_rem_s [DIV_STAGES];
	logic [63:0] div_quo_s [DIV_STAGES];
	logic [63:0] div_den_s [DIV_STAGES];
	logic [15:0] div_tc_s  [DIV_STAGES];
	logic [16:0] div_hum_s [DIV_STAGES];
	logic        div_neg_s [DIV_STAGES];
	logic        div_dz_s  [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [63:0] rem_in, quo_in, den_in, rem_sh;
		logic [15:0] tc_in;
		logic [16:0] hum_in;
		logic        neg_in, dz_in, v_in;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = an_s11;
			assign den_in = ad_s11;
			assign tc_in  = tc_s11;
			assign hum_in = hum_fin;
			assign neg_in = neg_s11;
			assign dz_in  = dz_s11;
			assign v_in   = v_s11;
		end else begin : g_next
			assign rem_in = div_rem_s[k-1];
			assign quo_in = div_quo_s[k-1];
			assign den_in = div_den_s[k-1];
			assign tc_in  = div_tc_s[k-1];
			assign hum_in = div_hum_s[k-1];
			assign neg_in = div_neg_s[k-1];
			assign dz_in  = div_dz_s[k-1];
			assign v_in   = div_v_s[k-1];
		end

		assign rem_sh = {rem_in[62:0], quo_in[63]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k] <= 1'b0;
			end else if (en) begin
				div_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_sh >= den_in) begin
					div_rem_s[k] <= rem_sh - den_in;
					div_quo_s[k] <= {quo_in[62:0], 1'b1};
				end else begin
					div_rem_s[k] <= rem_sh;
					div_quo_s[k] <= {quo_in[62:0], 1'b0};
				end
				div_den_s[k] <= den_in;
				div_tc_s[k]  <= tc_in;
				div_hum_s[k] <= hum_in;
				div_neg_s[k] <= neg_in;
				div_dz_s[k]  <= dz_in;
			end
		end
	end

	logic [63:0] qfin, qsh;
	logic [31:0] qcross;
	logic [63:0] p_s12, qsq_s12, p8p_s12, p_s13, p9q_s13, v2_s13, sum_s14;
	logic [31:0] press_s15;
	logic [15:0] tc_s12, tc_s13, tc_s14, tc_s15;
	logic [16:0] hum_s12, hum_s13, hum_s14, hum_s15;
	logic        dz_s12, dz_s13, dz_s14, dz_s15;
	logic [63:0] press_full;

	assign qfin = div_neg_s[DIV_STAGES-1] ? (64'd0 - div_quo_s[DIV_STAGES-1])
		: div_quo_s[DIV_STAGES-1];
	assign qsh        = $signed(qfin) >>> 13;
	assign qcross     = qsh[63:32] * qsh[31:0];
	assign press_full = sra64(sum_s14, 8) + (p7 << 4);

	// The square is needed modulo 2^64, so only the low half products take part.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s12     <= qfin;
			qsq_s12   <= 64'(qsh[31:0] * qsh[31:0]) + {qcross[30:0], 33'd0};
			p8p_s12   <= p8 * qfin;
			tc_s12    <= div_tc_s[DIV_STAGES-1];
			hum_s12   <= div_hum_s[DIV_STAGES-1];
			dz_s12    <= div_dz_s[DIV_STAGES-1];

			p_s13     <= p_s12;
			p9q_s13   <= qsq_s12 * p9;
			v2_s13    <= $signed(p8p_s12) >>> 19;
			tc_s13    <= tc_s12;
			hum_s13   <= hum_s12;
			dz_s13    <= dz_s12;

			sum_s14   <= p_s13 + sra64(p9q_s13, 25) + v2_s13;
			tc_s14    <= tc_s13;
			hum_s14   <= hum_s13;
			dz_s14    <= dz_s13;

			press_s15 <= dz_s14 ? 32'd0 : press_full[31:0];
			tc_s15    <= tc_s14;
			hum_s15   <= hum_s14;
			dz_s15    <= dz_s14;
		end
	end

	assign m_tvalid = v_s15;
	assign m_tdata  = {7'd0, hum_s15, press_s15, tc_s15};
	assign m_tuser  = !dz_s15;

`ifndef SYNTHESIS
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");
	a_press_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[47:16] == 32'd0)
		else $error("pressure nonzero on zero divisor");
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[64:48] <= 17'd102400)
		else $error("humidity above clamp");
	a_hum_absent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !hum_pres_q |-> m_tdata[64:48] == 17'd0)
		else $error("humidity nonzero without humidity channel");
`endif

endmodule

/* bench/sensor_trim_compensation_test.sv */
module sensor_trim_compensation_test;
	timeunit 1ns;
	timeprecision 1ps;

	import stc_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd6;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [15:0] temp;
		logic [31:0] press;
		logic        pvalid;
		logic [16:0] hum;
	} comp_t;

	typedef struct packed {
		logic [19:0] rt;
		logic [19:0] rp;
		logic [15:0] rh;
	} raw_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;   // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // temp_centi[15:0], press_q24_8[47:16], hum_q22_10[64:48]
	logic [0:0]  m_tuser;   // press_valid[0]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	logic [47:0] temp_trim;
	logic [63:0] press_lo;
	logic [63:0] press_hi;
	logic [15:0] press_p9;
	logic [63:0] hum_trim;
	logic        hum_on;

	comp_t comp_q[$];
	int    errors = 0;
	int    cycles = 0;
	bit    calm;
	bit    hold_req;
	bit    held;

	raw_t dir_rows[11] = '{
		'{20'h00000, 20'h00000, 16'h0000},
		'{20'hFFFFF, 20'hFFFFF, 16'hFFFF},
		'{20'hFFFFF, 20'h00000, 16'h0000},
		'{20'h00000, 20'hFFFFF, 16'hFFFF},
		'{20'h80000, 20'h80000, 16'h8000},
		'{20'h7FFFF, 20'h7FFFF, 16'h7FFF},
		'{20'd519888, 20'd415148, 16'd30000},
		'{20'h55555, 20'hAAAAA, 16'h5555},
		'{20'hAAAAA, 20'h55555, 16'hAAAA},
		'{20'h00001, 20'h00001, 16'h0001},
		'{20'd400000, 20'd300000, 16'd20000}
	};

	sensor_trim_compensation i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] sra32(logic [31:0] v, int n);
		return $signed(v) >>> n;
	endfunction

	function automatic logic [63:0] sra64(logic [63:0] v, int n);
		return $signed(v) >>> n;
	endfunction

	function automatic comp_t compensate(raw_t raw);
		logic [31:0] t1, t2, t3, adc, a, d, b, tf, tr;
		logic signed [31:0] tcs, s;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] v1, v2, p, q, num, an, ad;
		logic [31:0] h1, h2, h3, h4, h5, h6, x, lhs, rhs, y;
		comp_t r;
		r = '0;
		t1 = {16'd0, temp_trim[15:0]};
		t2 = {{16{temp_trim[31]}}, temp_trim[31:16]};
		t3 = {{16{temp_trim[47]}}, temp_trim[47:32]};
		adc = {12'd0, raw.rt};
		a = sra32(((adc >> 3) - (t1 << 1)) * t2, 11);
		d = (adc >> 4) - t1;
		b = sra32(sra32(d * d, 12) * t3, 14);
		tf = a + b;
		tr = sra32(tf * 32'd5 + 32'd128, 8);
		tcs = $signed(tr);
		if (tcs > 32767)
			r.temp = 16'h7FFF;
		else if (tcs < -32768)
			r.temp = 16'h8000;
		else
			r.temp = tr[15:0];

		p1 = {48'd0, press_lo[15:0]};
		p2 = {{48{press_lo[31]}}, press_lo[31:16]};
		p3 = {{48{press_lo[47]}}, press_lo[47:32]};
		p4 = {{48{press_lo[63]}}, press_lo[63:48]};
		p5 = {{48{press_hi[15]}}, press_hi[15:0]};
		p6 = {{48{press_hi[31]}}, press_hi[31:16]};
		p7 = {{48{press_hi[47]}}, press_hi[47:32]};
		p8 = {{48{press_hi[63]}}, press_hi[63:48]};
		p9 = {{48{press_p9[15]}}, press_p9};
		v1 = {{32{tf[31]}}, tf} - P_TEMP_OFS;
		v2 = v1 * v1 * p6 + ((v1 * p5) << 17) + (p4 << 35);
		v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
		v1 = sra64((P_ONE_47 + v1) * p1, 33);
		if (v1 != 64'd0) begin
			p = P_RAW_FULL - {44'd0, raw.rp};
			num = ((p << 31) - v2) * P_SCALE;
			an = num[63] ? -num : num;
			ad = v1[63] ? -v1 : v1;
			q = an / ad;
			p = (num[63] ^ v1[63]) ? -q : q;
			q = sra64(p, 13);
			v1 = sra64(p9 * q * q, 25);
			v2 = sra64(p8 * p, 19);
			p = sra64(p + v1 + v2, 8) + (p7 << 4);
			r.press = p[31:0];
			r.pvalid = 1'b1;
		end

		if (hum_on) begin
			h1 = {24'd0, hum_trim[7:0]};
			h2 = {{16{hum_trim[23]}}, hum_trim[23:8]};
			h3 = {24'd0, hum_trim[31:24]};
			h4 = {{20{hum_trim[43]}}, hum_trim[43:32]};
			h5 = {{20{hum_trim[55]}}, hum_trim[55:44]};
			h6 = {{24{hum_trim[63]}}, hum_trim[63:56]};
			x = tf - H_TEMP_OFS;
			lhs = sra32(({16'd0, raw.rh} << 14) - (h4 << 20) - (h5 * x) + H_ROUND_LHS, 15);
			rhs = sra32(x * h6, 10) * (sra32(x * h3, 11) + H_OFS_H3);
			rhs = sra32(rhs, 10) + H_OFS_RHS;
			rhs = sra32(rhs * h2 + H_ROUND_RHS, 14);
			x = lhs * rhs;
			y = sra32(x, 15);
			x = x - sra32(sra32(y * y, 7) * h1, 4);
			s = $signed(x);
			if (s < 0)
				s = 0;
			if (s > $signed(H_MAX))
				s = $signed(H_MAX);
			r.hum = s[28:12];
		end
		return r;
	endfunction

	task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_TEMP_TRIM: temp_trim = val[47:0];
			REG_PRESS_LOW: press_lo = val;
			REG_PRESS_HIGH: press_hi = val;
			REG_PRESS_LAST: press_p9 = val[15:0];
			REG_HUM_TRIM: hum_trim = val;
			REG_HUM_PRES: hum_on = val[0];
			default: ;
		endcase
	endtask

	task automatic set_trims(logic [63:0] t, logic [63:0] pl, logic [63:0] ph,
			logic [63:0] p9, logic [63:0] h, logic [63:0] hp);
		cfg_write(REG_TEMP_TRIM, t);
		cfg_write(REG_PRESS_LOW, pl);
		cfg_write(REG_PRESS_HIGH, ph);
		cfg_write(REG_PRESS_LAST, p9);
		cfg_write(REG_HUM_TRIM, h);
		cfg_write(REG_HUM_PRES, hp);
	endtask

	task automatic send_sample(raw_t raw, comp_t want);
		while (!calm && $urandom_range(99) < 34) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {raw.rh, raw.rp, raw.rt};
		do @(posedge clk); while (!s_tready);
		comp_q.push_back(want);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (comp_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		held = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 34);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	comp_t want;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (comp_q.size() == 0) begin
				$error("result beat with no expectation waiting");
				errors++;
			end else begin
				want = comp_q.pop_front();
				if (m_tdata[15:0] !== want.temp) begin
					$error("temp_centi expected %h got %h", want.temp, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[47:16] !== want.press) begin
					$error("press_q24_8 expected %h got %h", want.press, m_tdata[47:16]);
					errors++;
				end
				if (m_tuser[0] !== want.pvalid) begin
					$error("press_valid expected %b got %b", want.pvalid, m_tuser[0]);
					errors++;
				end
				if (m_tdata[64:48] !== want.hum) begin
					$error("hum_q22_10 expected %h got %h", want.hum, m_tdata[64:48]);
					errors++;
				end
			end
		end
	end

	initial begin
		raw_t raw;
		calm = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		temp_trim = '0;
		press_lo = '0;
		press_hi = '0;
		press_p9 = '0;
		hum_trim = '0;
		hum_on = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// All trims are zero after reset: zero divisor, no humidity, 0.00 degrees.
		foreach (dir_rows[i])
			send_sample(dir_rows[i], '0);
		drain();

		set_trims({16'hFC18, 16'd26435, 16'd27504},
			{16'd2855, 16'd3024, 16'hD643, 16'd36477},
			{16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
			64'd6000,
			{8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75},
			64'd1);
		cfg_write(REG_UNUSED, '1);
		foreach (dir_rows[i])
			send_sample(dir_rows[i], compensate(dir_rows[i]));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_trims('1, '1, '1, '1, '1, 64'd1);
				1: set_trims({16'h7FFF, 16'h7FFF, 16'h0000},
					{16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
					{16'h8000, 16'h8000, 16'h8000, 16'h8000},
					64'h8000,
					{8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF},
					64'd1);
				2: set_trims('0, '0, '0, '0, '0, 64'd0);
				3, 5: set_trims({16'hFC18 ^ 16'($urandom_range(255)), 16'd26435, 16'd27504},
					{16'd2855, 16'd3024, 16'hD643, 16'd36477},
					{16'hC6F8, 16'd15500, 16'hFFF9, 16'($urandom_range(255))},
					64'($urandom_range(8000)),
					{8'd30, 12'd50, 12'd313, 8'($urandom_range(255)), 16'd362, 8'd75},
					64'd1);
				default: set_trims(rand64(), rand64(), rand64(), rand64(), rand64(),
					64'($urandom_range(1)));
			endcase
			calm = (ph == 3);
			hold_req = (ph == 4);
			for (int n = 0; n < 50; n++) begin
				raw.rt = 20'($urandom);
				raw.rp = 20'($urandom);
				raw.rh = 16'($urandom);
				send_sample(raw, compensate(raw));
			end
			drain();
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

/* filelist.f */
rtl/stc_pkg.sv
rtl/sensor_trim_compensation.sv
bench/sensor_trim_compensation_test.sv
